// ----- hw/rtl/rprc_pkg.sv -----
// Shared types, register codes, predictor codes and the per-channel predictor function
// for the RGB predictive residual coder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rprc_pkg;

   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int QUEUE_DEPTH       = 4;
   localparam int SAMPLE_W          = 8;
   localparam int CSR_DATA_W        = 13;
   localparam int CSR_INDEX_W       = 1;
   localparam int SELECT_W          = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREDICTOR_SELECT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_WIDTH      = 13'd640;
   localparam logic [SELECT_W-1:0]   RESET_PREDICTOR_SELECT = 4'd7;

   localparam logic [SELECT_W-1:0] PRED_WEST      = 4'd0;
   localparam logic [SELECT_W-1:0] PRED_NORTH     = 4'd1;
   localparam logic [SELECT_W-1:0] PRED_NORTHWEST = 4'd2;
   localparam logic [SELECT_W-1:0] PRED_PLANE     = 4'd3;
   localparam logic [SELECT_W-1:0] PRED_NORTH_HW  = 4'd4;
   localparam logic [SELECT_W-1:0] PRED_WEST_HN   = 4'd5;
   localparam logic [SELECT_W-1:0] PRED_AVERAGE   = 4'd6;
   localparam logic [SELECT_W-1:0] PRED_MED       = 4'd7;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type red;
      sample_type green;
      sample_type blue;
   } rgb_type;

   typedef struct packed {
      rgb_type cur;
      rgb_type north;
      rgb_type west;
      rgb_type northwest;
   } nbr_type;

   function automatic sample_type half_toward_zero(input sample_type a, input sample_type b);
      logic [SAMPLE_W:0] d;
      logic [SAMPLE_W:0] dd;
      begin
         d  = {1'b0, a} - {1'b0, b};
         dd = d + {{SAMPLE_W{1'b0}}, d[SAMPLE_W]};
         return dd[SAMPLE_W:1];
      end
   endfunction

   function automatic sample_type predict(input logic [SELECT_W-1:0] mode, input sample_type n,
                                          input sample_type w, input sample_type nw);
      sample_type        hi;
      sample_type        lo;
      sample_type        plane;
      logic [SAMPLE_W:0] sum;
      sample_type        p;
      begin
         hi    = (n > w) ? n : w;
         lo    = (n > w) ? w : n;
         plane = n + w - nw;
         sum   = {1'b0, n} + {1'b0, w};
         unique case (mode)
            PRED_WEST:      p = w;
            PRED_NORTH:     p = n;
            PRED_NORTHWEST: p = nw;
            PRED_PLANE:     p = plane;
            PRED_NORTH_HW:  p = n + half_toward_zero(w, nw);
            PRED_WEST_HN:   p = w + half_toward_zero(n, nw);
            PRED_AVERAGE:   p = sum[SAMPLE_W:1];
            PRED_MED: begin
               if (nw >= hi) begin
                  p = hi;
               end else if (nw <= lo) begin
                  p = lo;
               end else begin
                  p = plane;
               end
            end
            default:        p = '0;
         endcase
         return p;
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rgb_predictive_residual_coder_top.sv -----
// RGB predictive residual coder: one pixel per cycle unless stalled, one residual beat per pixel.
// A pushed beat passes the front-end register and the queue and shows on the result ports once
// the result register takes it; a stalled result side delays it further.
// The front end, a four-entry queue and the back end stall independently.
// Reset clears position, queue and result and sets the image width register to 640 pixels;
// the line store is not cleared and holds data only for columns written since reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_predictive_residual_coder_top #(
   parameter int MAX_WIDTH = rprc_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [7:0]                          req_red_in,
   input  wire logic [7:0]                          req_green_in,
   input  wire logic [7:0]                          req_blue_in,
   input  wire logic                                req_frame_start,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [7:0]                               rsp_red_residual,
   output logic [7:0]                               rsp_green_residual,
   output logic [7:0]                               rsp_blue_residual,
   input  wire logic                                csr_we,
   input  wire logic [rprc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rprc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rprc_pkg::*;

   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic [CSR_DATA_W-1:0] image_width_ff;
   logic [SELECT_W-1:0]   predictor_select_ff;
   rgb_type               pixel;
   rgb_type               residual;
   nbr_type               front_item;
   nbr_type               head_item;
   logic                  front_valid;
   logic                  queue_empty;
   logic                  queue_take;
   logic [LW-1:0]         queue_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff      <= RESET_IMAGE_WIDTH;
         predictor_select_ff <= RESET_PREDICTOR_SELECT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:      image_width_ff      <= csr_wdata;
            CSR_PREDICTOR_SELECT: predictor_select_ff <= csr_wdata[SELECT_W-1:0];
         endcase
      end
   end

   assign pixel.red   = req_red_in;
   assign pixel.green = req_green_in;
   assign pixel.blue  = req_blue_in;

   rprc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .pixel       (pixel),
      .frame_start (req_frame_start),
      .image_width (image_width_ff),
      .queue_level (queue_level),
      .full        (req_full),
      .item_valid  (front_valid),
      .item        (front_item)
   );

   rprc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_item (front_item),
      .rd_en   (queue_take),
      .rd_item (head_item),
      .empty   (queue_empty),
      .level   (queue_level)
   );

   rprc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_ready       (!queue_empty),
      .item             (head_item),
      .predictor_select (predictor_select_ff),
      .item_take        (queue_take),
      .pop              (rsp_pop),
      .empty            (rsp_empty),
      .residual         (residual)
   );

   assign rsp_red_residual   = residual.red;
   assign rsp_green_residual = residual.green;
   assign rsp_blue_residual  = residual.blue;

endmodule

`default_nettype wire

// ----- hw/rtl/rprc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first on a same-address read and write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rprc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rprc_front.sv -----
// Front end: accepts pixels, tracks the raster position, reads and writes the line store
// and gathers the north, west and northwest neighbours. Depends on rprc_pkg and rprc_ram.
`timescale 1ns / 1ps
`default_nettype none

module rprc_front #(
   parameter int MAX_WIDTH = rprc_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      push,
   input  wire rprc_pkg::rgb_type                         pixel,
   input  wire logic                                      frame_start,
   input  wire logic [rprc_pkg::CSR_DATA_W-1:0]           image_width,
   input  wire logic [$clog2(rprc_pkg::QUEUE_DEPTH+1)-1:0] queue_level,
   output logic                                           full,
   output logic                                           item_valid,
   output rprc_pkg::nbr_type                              item
);
   import rprc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > CSR_DATA_W) ? CW + 1 : CSR_DATA_W;
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0] col_ff, col_in, col_cur;
   logic          first_row_ff, first_row_in, first_row_cur;
   logic          b_valid_ff;
   logic          b_first_row_ff;
   logic          b_col_zero_ff;
   rgb_type       b_cur_ff;
   rgb_type       west_ff;
   rgb_type       nw_ff;
   rgb_type       ram_rdata;
   rgb_type       north;
   logic [EW-1:0] width_ext, eff_width, col_next;
   logic          accept;
   logic [LW:0]   in_flight;

   assign in_flight = {1'b0, queue_level} + {{LW{1'b0}}, b_valid_ff};
   assign full      = in_flight >= (LW + 1)'(QUEUE_DEPTH);
   assign accept    = push && !full;

   assign col_cur       = frame_start ? '0 : col_ff;
   assign first_row_cur = frame_start ? 1'b1 : first_row_ff;

   always_comb begin
      width_ext = EW'(image_width);
      if (width_ext == '0) begin
         eff_width = EW'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      col_next = EW'(col_cur) + EW'(1);
      if (col_next >= eff_width) begin
         col_in       = '0;
         first_row_in = 1'b0;
      end else begin
         col_in       = col_next[CW-1:0];
         first_row_in = first_row_cur;
      end
   end

   rprc_ram #(
      .WIDTH ($bits(rgb_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_cur),
      .wr_data (pixel),
      .rd_addr (col_cur),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         b_valid_ff   <= 1'b0;
      end else begin
         b_valid_ff <= accept;
         if (accept) begin
            col_ff       <= col_in;
            first_row_ff <= first_row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_cur_ff       <= pixel;
         b_first_row_ff <= first_row_cur;
         b_col_zero_ff  <= (col_cur == '0);
      end
      if (b_valid_ff) begin
         west_ff <= b_cur_ff;
         nw_ff   <= north;
      end
   end

   assign north = b_first_row_ff ? '0 : ram_rdata;

   assign item_valid     = b_valid_ff;
   assign item.cur       = b_cur_ff;
   assign item.north     = north;
   assign item.west      = b_col_zero_ff ? '0 : west_ff;
   assign item.northwest = b_col_zero_ff ? '0 : nw_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rprc_queue.sv -----
// Short queue of neighbour sets between the front end and the back end.
// Depends on rprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rprc_queue (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      wr_en,
   input  wire rprc_pkg::nbr_type                         wr_item,
   input  wire logic                                      rd_en,
   output rprc_pkg::nbr_type                              rd_item,
   output logic                                           empty,
   output logic [$clog2(rprc_pkg::QUEUE_DEPTH+1)-1:0]     level
);
   import rprc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   nbr_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [LW-1:0] level_ff;
   logic          do_rd;

   assign empty   = (level_ff == '0);
   assign do_rd   = rd_en && !empty;
   assign rd_item = slot_ff[rd_ptr_ff];
   assign level   = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         level_ff <= level_ff + LW'(wr_en) - LW'(do_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rprc_back.sv -----
// Back end: forms the selected prediction per channel and registers the residual beat.
// Depends on rprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rprc_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             item_ready,
   input  wire rprc_pkg::nbr_type                item,
   input  wire logic [rprc_pkg::SELECT_W-1:0]    predictor_select,
   output logic                                  item_take,
   input  wire logic                             pop,
   output logic                                  empty,
   output rprc_pkg::rgb_type                     residual
);
   import rprc_pkg::*;

   logic    out_valid_ff;
   rgb_type residual_ff, residual_in;

   assign item_take = item_ready && (!out_valid_ff || pop);

   always_comb begin
      residual_in.red   = item.cur.red - predict(predictor_select, item.north.red,
                                                 item.west.red, item.northwest.red);
      residual_in.green = item.cur.green - predict(predictor_select, item.north.green,
                                                   item.west.green, item.northwest.green);
      residual_in.blue  = item.cur.blue - predict(predictor_select, item.north.blue,
                                                  item.west.blue, item.northwest.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (item_take) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         residual_ff <= residual_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign residual = residual_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rprc_checker.sv -----
// Port-level checker for the RGB predictive residual coder and its bind to the top level.
// Depends on rprc_pkg and rgb_predictive_residual_coder_top.
`timescale 1ns / 1ps
`default_nettype none

module rprc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_push,
   input wire logic                             req_full,
   input wire logic                             rsp_empty,
   input wire logic                             rsp_pop,
   input wire logic [7:0]                       rsp_red_residual,
   input wire logic [7:0]                       rsp_green_residual,
   input wire logic [7:0]                       rsp_blue_residual
);

   // After reset nothing is held and the input side is open.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result not empty or input full after reset");

   // An accepted beat must reach the result ports.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |-> ##3 !rsp_empty)
      else $error("accepted beat did not reach the result ports");

   // A waiting result that is not taken stays unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_red_residual) && $stable(rsp_green_residual)
          && $stable(rsp_blue_residual)))
      else $error("waiting result changed before it was taken");

endmodule

bind rgb_predictive_residual_coder_top rprc_checker u_checker (.*);

`default_nettype wire
